[rtl/core/swrms_pkg.sv]
// Shared constants, field widths and record types of the sliding-window RMS meter.
// Used by swrms_fifo, swrms_front, swrms_back and the top level; no dependencies.
package swrms_pkg;

	localparam int WINDOW_DEF      = 400;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 25;
	localparam int SQ_W     = 39;
	localparam int RES_W    = 24;
	localparam int RATIO_W  = 16;

	// Fixed-point scaling of the results.
	localparam int FRAC_SHIFT  = 16;
	localparam int MEAN_SHIFT  = 9;
	localparam int RATIO_SHIFT = 22;

	// Bits resolved per clock in the iterative units.
	localparam int DIV_STEP  = 4;
	localparam int SQRT_STEP = 2;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_PUSH    = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] old;
	} meas_t;

	typedef struct packed {
		logic                ratio_invalid;
		logic [RATIO_W-1:0]  phase_ratio;
		logic [RES_W-1:0]    rms_ac_value;
		logic [RES_W-1:0]    rms_value;
		logic [RES_W-1:0]    mean_value;
	} res_t;

endpackage

[rtl/core/swrms_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module swrms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 400
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/swrms_div.sv]
// Iterative restoring divider, STEP quotient bits per clock.
// No dependencies; instantiated by swrms_back.
module swrms_div #(
	parameter int N    = 34,
	parameter int D    = 10,
	parameter int STEP = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quotient
);

	localparam int ITER = (N + STEP - 1) / STEP;
	localparam int NP   = ITER * STEP;
	localparam int CW   = $clog2(ITER + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NP-1:0] dq_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  dvs_q;
	logic [NP-1:0] dq_n;
	logic [D-1:0]  rem_n;

	// The dividend shifts out of the top while quotient bits fill in from the bottom.
	always_comb begin
		logic [D:0]    t;
		logic [D-1:0]  r;
		logic [NP-1:0] d;
		r = rem_q;
		d = dq_q;
		for (int i = 0; i < STEP; i++) begin
			t = {r, d[NP-1]};
			d = d << 1;
			if (t >= {1'b0, dvs_q}) begin
				r = D'(t - {1'b0, dvs_q});
				d[0] = 1'b1;
			end else begin
				r = t[D-1:0];
			end
		end
		rem_n = r;
		dq_n  = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITER);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= NP'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q[N-1:0];

endmodule

[rtl/core/swrms_sqrt.sv]
// Iterative integer square root (floor), STEP result bits per clock.
// No dependencies; instantiated by swrms_back.
module swrms_sqrt #(
	parameter int N    = 55,
	parameter int STEP = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [N-1:0]         radicand,
	output logic                 busy,
	output logic [(N+1)/2-1:0]   root
);

	localparam int R    = (N + 1) / 2;
	localparam int ITER = (R + STEP - 1) / STEP;
	localparam int RP   = ITER * STEP;
	localparam int NPP  = 2 * RP;
	localparam int CW   = $clog2(ITER + 1);

	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [NPP-1:0] rad_q;
	logic [RP+1:0]  rem_q;
	logic [RP-1:0]  root_q;
	logic [NPP-1:0] rad_n;
	logic [RP+1:0]  rem_n;
	logic [RP-1:0]  root_n;

	// Digit-by-digit method: bring down two radicand bits, try 4*root+1.
	always_comb begin
		logic [RP+3:0]  t;
		logic [RP+3:0]  trial;
		logic [RP+1:0]  r;
		logic [RP-1:0]  q;
		logic [NPP-1:0] a;
		r = rem_q;
		q = root_q;
		a = rad_q;
		for (int i = 0; i < STEP; i++) begin
			t     = {r, a[NPP-1:NPP-2]};
			a     = a << 2;
			trial = (RP+4)'({q, 2'b01});
			if (t >= trial) begin
				r = (RP+2)'(t - trial);
				q = (q << 1) | RP'(1);
			end else begin
				r = (RP+2)'(t);
				q = q << 1;
			end
		end
		rem_n  = r;
		root_n = q;
		rad_n  = a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITER);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= NPP'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_n;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	assign busy = busy_q;
	assign root = root_q[R-1:0];

endmodule

[rtl/core/swrms_fifo.sv]
// Short request queue between the front end and the arithmetic back end.
// Depends on swrms_pkg for the queued record type.
module swrms_fifo #(
	parameter int DEPTH = swrms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  swrms_pkg::meas_t   push_data,
	output logic               full,
	input  logic               pop,
	output swrms_pkg::meas_t   pop_data,
	output logic               empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	swrms_pkg::meas_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/core/swrms_front.sv]
// Front end: accepts requests, owns the sample ring and its clearing pass,
// and forwards measure requests to the queue. Depends on swrms_pkg and swrms_ram.
module swrms_front #(
	parameter int WINDOW = swrms_pkg::WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 opcode,
	input  logic signed [swrms_pkg::SAMPLE_W-1:0] sample,
	output logic                                 q_push,
	output swrms_pkg::meas_t                     q_data,
	input  logic                                 q_full
);

	localparam int POS_W = $clog2(WINDOW);

	logic                                  clr_busy_q;
	logic [POS_W-1:0]                      clr_addr_q;
	logic [POS_W-1:0]                      pos_q;
	logic                                  v_s1;
	logic                                  op_s1;
	logic signed [swrms_pkg::SAMPLE_W-1:0] x_s1;
	logic [POS_W-1:0]                      pos_s1;
	logic                                  accept;
	logic                                  retire;
	logic                                  ram_we;
	logic [POS_W-1:0]                      ram_waddr;
	logic [swrms_pkg::SAMPLE_W-1:0]        ram_wdata;
	logic [swrms_pkg::SAMPLE_W-1:0]        ram_rdata;

	// A request in stage 1 leaves once its ring slot is written; a measure also needs queue room.
	assign retire   = v_s1 && ((op_s1 == swrms_pkg::OP_PUSH) || !q_full);
	assign in_ready = !clr_busy_q && (!v_s1 || retire);
	assign accept   = in_valid && in_ready;

	assign ram_we    = clr_busy_q || retire;
	assign ram_waddr = clr_busy_q ? clr_addr_q : pos_s1;
	assign ram_wdata = clr_busy_q ? '0 : x_s1;

	assign q_push     = retire && (op_s1 == swrms_pkg::OP_MEASURE);
	assign q_data.x   = x_s1;
	assign q_data.old = $signed(ram_rdata);

	swrms_ram #(
		.WIDTH (swrms_pkg::SAMPLE_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			pos_q      <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == POS_W'(WINDOW - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				pos_q <= (pos_q == POS_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
				v_s1  <= 1'b1;
			end else if (retire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			x_s1   <= sample;
			pos_s1 <= pos_q;
		end
	end

endmodule

[rtl/core/swrms_back.sv]
// Back end: keeps the running sums and computes mean, RMS, AC RMS and ratio
// with iterative units. Depends on swrms_pkg, swrms_div and swrms_sqrt.
module swrms_back #(
	parameter int WINDOW = swrms_pkg::WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_pop,
	input  swrms_pkg::meas_t  q_data,
	output logic              res_valid,
	input  logic              res_ready,
	output swrms_pkg::res_t   res
);

	localparam int SAMPLE_W = swrms_pkg::SAMPLE_W;
	localparam int SUM_W    = swrms_pkg::SUM_W;
	localparam int SQ_W     = swrms_pkg::SQ_W;
	localparam int RES_W    = swrms_pkg::RES_W;
	localparam int RATIO_W  = swrms_pkg::RATIO_W;
	localparam int FRAC     = swrms_pkg::FRAC_SHIFT;
	localparam int MSH      = swrms_pkg::MEAN_SHIFT;
	localparam int RSH      = swrms_pkg::RATIO_SHIFT;

	localparam int WIN_W  = $clog2(WINDOW + 1);
	localparam int W2_W   = $clog2(WINDOW * WINDOW + 1);
	localparam int QW_W   = SQ_W + WIN_W;
	localparam int SS_W   = 2 * SUM_W;
	localparam int NUM_W  = (QW_W > SS_W) ? QW_W : SS_W;
	localparam int MD_N   = SUM_W + MSH;
	localparam int RT_N   = SQ_W + FRAC;
	localparam int AC_N   = NUM_W + FRAC;
	localparam int RD_N   = SAMPLE_W + RSH;
	localparam int ROOT_W = (RT_N + 1) / 2;

	localparam int MEAN_POS_MAX  = 2 ** (RES_W - 1) - 1;
	localparam int MEAN_NEG_MAX  = 2 ** (RES_W - 1);
	localparam int RATIO_POS_MAX = 2 ** (RATIO_W - 1) - 1;
	localparam int RATIO_NEG_MAX = 2 ** (RATIO_W - 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQR  = 4'd1;
	localparam logic [3:0] ST_ACC  = 4'd2;
	localparam logic [3:0] ST_PREP = 4'd3;
	localparam logic [3:0] ST_NUM  = 4'd4;
	localparam logic [3:0] ST_WDIV = 4'd5;
	localparam logic [3:0] ST_WSQ  = 4'd6;
	localparam logic [3:0] ST_WRAT = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]                   state_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [SQ_W-1:0]              sq_q;
	logic signed [SAMPLE_W-1:0]   x_q;
	logic signed [SAMPLE_W-1:0]   old_q;
	logic [2*SAMPLE_W-1:0]        xx_q;
	logic [2*SAMPLE_W-1:0]        oo_q;
	logic [SS_W-1:0]              ss_q;
	logic [QW_W-1:0]              qw_q;
	logic                         neg_q;
	logic [RES_W-1:0]             mean_q;
	logic [RES_W-1:0]             rms_q;
	logic [RES_W-1:0]             ac_q;
	logic [RATIO_W-1:0]           ratio_q;
	logic                         inv_q;
	logic                         res_valid_q;
	swrms_pkg::res_t              res_q;

	logic signed [2*SAMPLE_W-1:0] xx_c;
	logic signed [2*SAMPLE_W-1:0] oo_c;
	logic [SUM_W-1:0]             mag_c;
	logic signed [NUM_W:0]        diff_c;
	logic [NUM_W-1:0]             n_c;
	logic [SAMPLE_W-1:0]          xm_c;
	logic [RES_W-1:0]             mean_c;
	logic [RES_W-1:0]             rms_sat_c;
	logic [RES_W-1:0]             ac_sat_c;
	logic [RATIO_W-1:0]           ratio_c;
	logic                         load;

	logic             md_start, md_busy;
	logic [MD_N-1:0]  md_dividend, md_quo;
	logic             rt_start, rt_busy;
	logic [RT_N-1:0]  rt_dividend, rt_quo;
	logic             ac_start, ac_busy;
	logic [AC_N-1:0]  ac_dividend, ac_quo;
	logic             rd_start, rd_busy;
	logic [RD_N-1:0]  rd_dividend, rd_quo;
	logic             sq_start, rs_busy, as_busy;
	logic [ROOT_W-1:0] rs_root, as_root;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	assign xx_c  = x_q * x_q;
	assign oo_c  = old_q * old_q;
	assign mag_c = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign xm_c  = x_q[SAMPLE_W-1] ? SAMPLE_W'(-x_q) : SAMPLE_W'(x_q);

	// Q*W - S*S may go negative after rounding or drift; it is clamped to zero.
	assign diff_c = $signed({1'b0, NUM_W'(qw_q)}) - $signed({1'b0, NUM_W'(ss_q)});
	assign n_c    = diff_c[NUM_W] ? '0 : diff_c[NUM_W-1:0];

	assign md_start    = (state_q == ST_PREP);
	assign rt_start    = (state_q == ST_PREP);
	assign ac_start    = (state_q == ST_NUM);
	assign sq_start    = (state_q == ST_WDIV) && !md_busy && !rt_busy && !ac_busy;
	assign rd_start    = (state_q == ST_WSQ) && !rs_busy && !as_busy && (rms_sat_c != '0);

	assign md_dividend = MD_N'({mag_c, {MSH{1'b0}}}) + MD_N'(WINDOW);
	assign rt_dividend = {sq_q, {FRAC{1'b0}}};
	assign ac_dividend = {n_c, {FRAC{1'b0}}};
	assign rd_dividend = {xm_c, {RSH{1'b0}}};

	assign rms_sat_c = (|rs_root[ROOT_W-1:RES_W]) ? '1 : rs_root[RES_W-1:0];
	assign ac_sat_c  = (|as_root[ROOT_W-1:RES_W]) ? '1 : as_root[RES_W-1:0];

	always_comb begin
		if (neg_q) begin
			mean_c = (md_quo > MD_N'(MEAN_NEG_MAX)) ? RES_W'(MEAN_NEG_MAX) : RES_W'(-md_quo);
		end else begin
			mean_c = (md_quo > MD_N'(MEAN_POS_MAX)) ? RES_W'(MEAN_POS_MAX) : md_quo[RES_W-1:0];
		end
	end

	always_comb begin
		if (x_q[SAMPLE_W-1]) begin
			ratio_c = (rd_quo > RD_N'(RATIO_NEG_MAX)) ? RATIO_W'(RATIO_NEG_MAX)
				: RATIO_W'(-rd_quo);
		end else begin
			ratio_c = (rd_quo > RD_N'(RATIO_POS_MAX)) ? RATIO_W'(RATIO_POS_MAX)
				: rd_quo[RATIO_W-1:0];
		end
	end

	swrms_div #(.N(MD_N), .D(WIN_W + 1), .STEP(swrms_pkg::DIV_STEP)) u_mean_div (
		.clk(clk), .arst_n(arst_n), .start(md_start), .dividend(md_dividend),
		.divisor((WIN_W + 1)'(2 * WINDOW)), .busy(md_busy), .quotient(md_quo)
	);

	swrms_div #(.N(RT_N), .D(WIN_W), .STEP(swrms_pkg::DIV_STEP)) u_rms_div (
		.clk(clk), .arst_n(arst_n), .start(rt_start), .dividend(rt_dividend),
		.divisor(WIN_W'(WINDOW)), .busy(rt_busy), .quotient(rt_quo)
	);

	swrms_div #(.N(AC_N), .D(W2_W), .STEP(swrms_pkg::DIV_STEP)) u_ac_div (
		.clk(clk), .arst_n(arst_n), .start(ac_start), .dividend(ac_dividend),
		.divisor(W2_W'(WINDOW * WINDOW)), .busy(ac_busy), .quotient(ac_quo)
	);

	swrms_div #(.N(RD_N), .D(RES_W), .STEP(swrms_pkg::DIV_STEP)) u_ratio_div (
		.clk(clk), .arst_n(arst_n), .start(rd_start), .dividend(rd_dividend),
		.divisor(rms_sat_c), .busy(rd_busy), .quotient(rd_quo)
	);

	swrms_sqrt #(.N(RT_N), .STEP(swrms_pkg::SQRT_STEP)) u_rms_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(rt_quo),
		.busy(rs_busy), .root(rs_root)
	);

	// The AC quotient never exceeds Q*2^16/W, so its upper bits are always zero.
	swrms_sqrt #(.N(RT_N), .STEP(swrms_pkg::SQRT_STEP)) u_ac_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(ac_quo[RT_N-1:0]),
		.busy(as_busy), .root(as_root)
	);

	assign load = (state_q == ST_DONE) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			sq_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					sum_q   <= sum_q - SUM_W'(old_q) + SUM_W'(x_q);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sq_q    <= sq_q - SQ_W'(oo_q) + SQ_W'(xx_q);
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_WDIV;
				end
				ST_WDIV: begin
					if (sq_start) begin
						state_q <= ST_WSQ;
					end
				end
				ST_WSQ: begin
					if (!rs_busy && !as_busy) begin
						state_q <= (rms_sat_c == '0) ? ST_DONE : ST_WRAT;
					end
				end
				ST_WRAT: begin
					if (!rd_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q   <= q_data.x;
			old_q <= q_data.old;
		end
		if (state_q == ST_SQR) begin
			xx_q <= xx_c;
			oo_q <= oo_c;
		end
		if (state_q == ST_PREP) begin
			ss_q  <= SS_W'(mag_c * mag_c);
			qw_q  <= QW_W'(sq_q * QW_W'(WINDOW));
			neg_q <= sum_q[SUM_W-1];
		end
		if (sq_start) begin
			mean_q <= mean_c;
		end
		if ((state_q == ST_WSQ) && !rs_busy && !as_busy) begin
			rms_q   <= rms_sat_c;
			ac_q    <= ac_sat_c;
			inv_q   <= (rms_sat_c == '0);
			ratio_q <= '0;
		end
		if ((state_q == ST_WRAT) && !rd_busy) begin
			ratio_q <= ratio_c;
		end
		if (load) begin
			res_q.mean_value    <= mean_q;
			res_q.rms_value     <= rms_q;
			res_q.rms_ac_value  <= ac_q;
			res_q.phase_ratio   <= ratio_q;
			res_q.ratio_invalid <= inv_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[rtl/core/sliding_window_rms_meter.sv]
// Top level of the sliding-window RMS meter: front end, request queue, back end.
// Depends on swrms_pkg, swrms_front, swrms_fifo and swrms_back.
//
// Usage. Requests arrive on the s_axis channel: tuser is the opcode (0 measures,
// 1 only pushes the sample into the window) and tdata is the signed sample.
// A measure swaps the sample into the running sum and sum of squares and yields
// one result on m_axis: mean, RMS and AC RMS with 8 fraction bits, the sample
// divided by the RMS in Q2.14, and a flag in tuser when the RMS is zero.
// A push request yields no result.
//
// Throughput. The front end takes one request per clock as long as
// the queue has room; a push request needs no queue room but can wait behind
// a measure that does. Each measure occupies the back end for one pass: the
// multiplies, the longest of three 4-bit-per-clock divides (the AC divide),
// two parallel square roots and, when the RMS is nonzero, the 4-bit-per-clock
// ratio divide. The back end takes the next measure from the queue only after
// the last result is loaded into its output register, so that back-end pass
// sets the sustained measure rate.
//
// Reset. After arst_n rises the front end zeroes the window memory, one entry a
// clock, and s_axis_tready stays low until every entry is cleared.
// When m_axis_tready is low the finished result waits in its output register;
// the back end holds its next result and the queue and front end keep taking
// requests until the queue fills.
module sliding_window_rms_meter #(
	parameter int WINDOW      = swrms_pkg::WINDOW_DEF,
	parameter int QUEUE_DEPTH = swrms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic        s_axis_tuser,   // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // [23:0] mean_value, [47:24] rms_value,
	                                    // [71:48] rms_ac_value, [87:72] phase_ratio
	output logic        m_axis_tuser    // [0] ratio_invalid
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	swrms_pkg::meas_t q_wdata;
	swrms_pkg::meas_t q_rdata;
	swrms_pkg::res_t  res;

	// Front end: request acceptance, window memory and its clearing pass.
	swrms_front #(
		.WINDOW (WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.opcode   (s_axis_tuser),
		.sample   ($signed(s_axis_tdata)),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.q_full   (q_full)
	);

	// Measure requests carry the new sample and the one it displaces.
	swrms_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// Back end: running sums and all result arithmetic.
	swrms_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_rdata),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.phase_ratio, res.rms_ac_value, res.rms_value, res.mean_value};
	assign m_axis_tuser = res.ratio_invalid;

endmodule
